@@ rtl/core/double_ended_queue_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the double-ended queue unit.
// The properties are clocked on clk and disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property at every clock edge outside reset.
`define DEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define DEQ_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`else

`define DEQ_ASSERT(label, prop, msg)
`define DEQ_ASSERT_NEXT(label, trig, prop, msg)

`endif

`endif

@@ rtl/core/deq_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deq_pkg
// Shared widths, request codes and status codes of the double-ended queue.
// ---------------------------------------------------------------------------
package deq_pkg;

  // Default number of slots in the ring store.
  localparam int DEPTH_DEFAULT = 64;

  // Payload widths.
  localparam int VALUE_W  = 32;
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Request codes.
  localparam req_t REQ_PUSH_FRONT = 3'd0;
  localparam req_t REQ_PUSH_BACK  = 3'd1;
  localparam req_t REQ_POP_FRONT  = 3'd2;
  localparam req_t REQ_POP_BACK   = 3'd3;
  localparam req_t REQ_DUMP       = 3'd4;

  // Status codes.
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

@@ rtl/core/deq_mem.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deq_mem
// Entry store: one write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module deq_mem #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [$clog2(DEPTH)-1:0]            wr_addr,
  input  logic signed [deq_pkg::VALUE_W-1:0]  wr_data,
  input  logic                                rd_en,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr,
  output logic signed [deq_pkg::VALUE_W-1:0]  rd_data
);

  logic signed [deq_pkg::VALUE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data register holds its value between reads.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/deq_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deq_ctrl
// Ring pointers, request decode, dump sequencer and the result register.
// ---------------------------------------------------------------------------
`include "double_ended_queue_unit_defines.svh"

module deq_ctrl #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // Request channel.
  input  logic                                req_valid,
  output logic                                req_stall,
  input  deq_pkg::req_t                       req_type,
  input  logic signed [deq_pkg::VALUE_W-1:0]  push_value,
  // Result channel.
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic signed [deq_pkg::VALUE_W-1:0]  out_value,
  output deq_pkg::status_t                    status,
  output logic                                last,
  // Entry store.
  output logic                                wr_en,
  output logic [$clog2(DEPTH)-1:0]            wr_addr,
  output logic signed [deq_pkg::VALUE_W-1:0]  wr_data,
  output logic                                rd_en,
  output logic [$clog2(DEPTH)-1:0]            rd_addr,
  input  logic signed [deq_pkg::VALUE_W-1:0]  rd_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic             state, state_next;
  logic [PTR_W-1:0] front, front_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] dump_idx, dump_idx_next;
  logic             rd_pending;
  logic             rd_last, rd_last_next;

  logic             out_free;
  logic             move;
  logic             mem_free;
  logic             accept;
  logic             is_full;
  logic             is_empty;
  logic [PTR_W-1:0] front_dec;
  logic [PTR_W-1:0] front_inc;
  logic [CNT_W-1:0] offset;
  logic [SUM_W-1:0] slot_sum;
  logic [SUM_W-1:0] slot_wrap;
  logic [PTR_W-1:0] slot;
  logic             imm_load;
  deq_pkg::status_t imm_status;

  // Handshake bookkeeping. An item is taken only when nothing is in flight
  // and the result register can take its result.
  assign out_free  = !rsp_valid || !rsp_stall;
  assign move      = rd_pending && out_free;
  assign mem_free  = !rd_pending || move;
  assign req_stall = !((state == S_IDLE) && !rd_pending && out_free);
  assign accept    = req_valid && !req_stall;

  assign is_full  = (count == CNT_FULL);
  assign is_empty = (count == '0);

  // Front pointer neighbors, wrapping at the store depth.
  assign front_dec = (front == '0) ? PTR_LAST : front - 1'b1;
  assign front_inc = (front == PTR_LAST) ? '0 : front + 1'b1;

  // Offset from the front: back slot for a push, last entry for a back pop,
  // running position for a dump.
  always_comb begin
    if (state == S_DUMP) begin
      offset = dump_idx;
    end else if (req_type == deq_pkg::REQ_POP_BACK) begin
      offset = count - 1'b1;
    end else begin
      offset = count;
    end
  end

  // Ring address: the sum stays below twice the depth, so one subtract wraps it.
  assign slot_sum  = SUM_W'(front) + SUM_W'(offset);
  assign slot_wrap = (slot_sum >= SUM_DEPTH) ? slot_sum - SUM_DEPTH : slot_sum;
  assign slot      = slot_wrap[PTR_W-1:0];

  assign wr_data = push_value;

  // Request decode and dump sequencing.
  always_comb begin
    state_next    = state;
    front_next    = front;
    count_next    = count;
    dump_idx_next = dump_idx;
    rd_last_next  = rd_last;
    wr_en         = 1'b0;
    wr_addr       = slot;
    rd_en         = 1'b0;
    rd_addr       = slot;
    imm_load      = 1'b0;
    imm_status    = deq_pkg::ST_OK;

    if (state == S_DUMP) begin
      if (mem_free) begin
        rd_en         = 1'b1;
        rd_last_next  = (dump_idx == count - 1'b1);
        dump_idx_next = dump_idx + 1'b1;
        if (dump_idx == count - 1'b1) begin
          state_next = S_IDLE;
        end
      end
    end else if (accept) begin
      case (req_type)
        deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
          imm_load = 1'b1;
          if (is_full) begin
            imm_status = deq_pkg::ST_FULL;
          end else begin
            wr_en      = 1'b1;
            count_next = count + 1'b1;
            if (req_type == deq_pkg::REQ_PUSH_FRONT) begin
              wr_addr    = front_dec;
              front_next = front_dec;
            end
          end
        end
        deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
          if (is_empty) begin
            imm_load   = 1'b1;
            imm_status = deq_pkg::ST_EMPTY;
          end else begin
            rd_en        = 1'b1;
            rd_last_next = 1'b1;
            count_next   = count - 1'b1;
            if (req_type == deq_pkg::REQ_POP_FRONT) begin
              rd_addr    = front;
              front_next = front_inc;
            end
          end
        end
        deq_pkg::REQ_DUMP: begin
          if (is_empty) begin
            imm_load   = 1'b1;
            imm_status = deq_pkg::ST_EMPTY;
          end else begin
            state_next    = S_DUMP;
            dump_idx_next = '0;
          end
        end
        default: begin
          // Unused request codes are dropped without a result.
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      front      <= '0;
      count      <= '0;
      dump_idx   <= '0;
      rd_pending <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      front    <= front_next;
      count    <= count_next;
      dump_idx <= dump_idx_next;
      if (rd_en) begin
        rd_pending <= 1'b1;
      end else if (move) begin
        rd_pending <= 1'b0;
      end
      if (move || imm_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Last flag of the read in flight.
  always_ff @(posedge clk) begin
    rd_last <= rd_last_next;
  end

  // Result register: read data or an immediate status result.
  always_ff @(posedge clk) begin
    if (move) begin
      out_value <= rd_data;
      status    <= deq_pkg::ST_OK;
      last      <= rd_last;
    end else if (imm_load) begin
      out_value <= '0;
      status    <= imm_status;
      last      <= 1'b1;
    end
  end

  // The entry count never passes the depth.
  `DEQ_ASSERT(a_count_range, count <= CNT_FULL, "entry count above depth")
  // A dump only runs over a non-empty store.
  `DEQ_ASSERT(a_dump_nonempty, (state != S_DUMP) || (count != '0), "dump of an empty store")
  // A successful pop removes exactly one entry.
  `DEQ_ASSERT_NEXT(a_pop_count,
      accept && !is_empty && ((req_type == deq_pkg::REQ_POP_FRONT) ||
      (req_type == deq_pkg::REQ_POP_BACK)),
      count == CNT_W'($past(count) - 1'b1), "pop did not decrement count")
  // Read data waiting on a stalled result register is kept.
  `DEQ_ASSERT_NEXT(a_read_held, rd_pending && !out_free,
      rd_pending && $stable(rd_data), "pending read data lost")

endmodule

@@ rtl/core/double_ended_queue_unit.sv @@
`timescale 1ns / 1ps
// Push, failed pop, empty dump: one per cycle if unstalled; result registered next cycle.
// Pop: registered store read; requests stall until the data enters the result register.
// Dump of N entries: acceptance, N reads one per cycle unless stalled, last handoff.
// Reset clears the front pointer and the count; the store is not cleared.
// ---------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed 32-bit values in a ring store.
// ---------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  deq_pkg::req_t                       req_type,
  input  logic signed [deq_pkg::VALUE_W-1:0]  push_value,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic signed [deq_pkg::VALUE_W-1:0]  out_value,
  output deq_pkg::status_t                    status,
  output logic                                last
);

  localparam int PTR_W = $clog2(DEPTH);

  logic                               wr_en;
  logic [PTR_W-1:0]                   wr_addr;
  logic signed [deq_pkg::VALUE_W-1:0] wr_data;
  logic                               rd_en;
  logic [PTR_W-1:0]                   rd_addr;
  logic signed [deq_pkg::VALUE_W-1:0] rd_data;

  // Pointer and sequencing logic.
  deq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .push_value (push_value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .out_value  (out_value),
    .status     (status),
    .last       (last),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  // Entry store.
  deq_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

@@ tb/double_ended_queue_unit_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_ended_queue_unit_tb
// Self-checking bench for the double-ended queue unit. A scoreboard keeps
// its own ring store, front pointer and count. It predicts every result of
// each accepted request and compares the results in order. Stimulus starts
// with directed corner cases. Random bursts follow that fill the store to
// full, drain it to empty and mix all requests, under three idling profiles.
// ---------------------------------------------------------------------------
module double_ended_queue_unit_tb;

  localparam int DEPTH          = deq_pkg::DEPTH_DEFAULT;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int PHASE_ITEMS    = 95;
  localparam int MAX_PRINTS     = 50;

  typedef logic signed [deq_pkg::VALUE_W-1:0] value_t;

  typedef struct packed {
    value_t           value;
    deq_pkg::status_t status;
    logic             last;
  } result_t;

  // Predicts the results of each request and checks them in order.
  class deque_scoreboard;
    value_t      mirror_slots[DEPTH];
    int          mirror_head;
    int          mirror_count;
    result_t     pending_results[$];
    int          error_count;
    int          checked_count;
    int          full_hits;
    int          empty_hits;

    function new();
      mirror_head   = 0;
      mirror_count  = 0;
      error_count   = 0;
      checked_count = 0;
      full_hits     = 0;
      empty_hits    = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report(string msg);
      if (error_count < MAX_PRINTS) begin
        $display("MISMATCH @%0t: %s", $time, msg);
      end
      error_count++;
    endtask

    function void expect_one(value_t value, deq_pkg::status_t st, logic is_last);
      result_t r;
      r.value  = value;
      r.status = st;
      r.last   = is_last;
      pending_results.push_back(r);
      if (st == deq_pkg::ST_FULL) full_hits++;
      if (st == deq_pkg::ST_EMPTY) empty_hits++;
    endfunction

    // Updates the mirrored deque for one accepted request.
    function void note_request(deq_pkg::req_t kind, value_t value);
      int slot;
      case (kind)
        deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
          if (mirror_count >= DEPTH) begin
            expect_one('0, deq_pkg::ST_FULL, 1'b1);
          end else begin
            if (kind == deq_pkg::REQ_PUSH_FRONT) begin
              mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
              slot = mirror_head;
            end else begin
              slot = (mirror_head + mirror_count) % DEPTH;
            end
            mirror_slots[slot] = value;
            mirror_count++;
            expect_one('0, deq_pkg::ST_OK, 1'b1);
          end
        end
        deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
          if (mirror_count == 0) begin
            expect_one('0, deq_pkg::ST_EMPTY, 1'b1);
          end else begin
            if (kind == deq_pkg::REQ_POP_FRONT) begin
              slot = mirror_head;
              mirror_head = (mirror_head + 1) % DEPTH;
            end else begin
              slot = (mirror_head + mirror_count - 1) % DEPTH;
            end
            mirror_count--;
            expect_one(mirror_slots[slot], deq_pkg::ST_OK, 1'b1);
          end
        end
        deq_pkg::REQ_DUMP: begin
          if (mirror_count == 0) begin
            expect_one('0, deq_pkg::ST_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < mirror_count; i++) begin
              expect_one(mirror_slots[(mirror_head + i) % DEPTH], deq_pkg::ST_OK,
                         (i + 1 == mirror_count));
            end
          end
        end
        default: ;  // Unused codes are ignored by the block.
      endcase
    endfunction

    // Compares one accepted result with the oldest expectation.
    task check_result(value_t value, deq_pkg::status_t st, logic is_last);
      result_t exp_r;
      checked_count++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result value=%0d status=%0d last=%0b",
                         value, st, is_last));
      end else begin
        exp_r = pending_results.pop_front();
        if (value !== exp_r.value || st !== exp_r.status || is_last !== exp_r.last) begin
          report($sformatf("got value=%0d status=%0d last=%0b, want %0d/%0d/%0b",
                           value, st, is_last, exp_r.value, exp_r.status, exp_r.last));
        end
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  deq_pkg::req_t    req_type = deq_pkg::REQ_PUSH_FRONT;
  value_t           push_value = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  value_t           out_value;
  deq_pkg::status_t status;
  logic             last;

  deque_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int requests_sent = 0;
  int ignored_sent  = 0;
  int idle_cycles   = 0;

  double_ended_queue_unit #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .push_value (push_value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .out_value  (out_value),
    .status     (status),
    .last       (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: check accepted results and stall at random.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      sb.check_result(out_value, status, last);
    end
    rsp_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: ends the run when nothing is accepted for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly random values, with the extremes mixed in.
  function automatic value_t pick_value();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return value_t'($urandom);
    endcase
  endfunction

  // Drives one request and waits until it is accepted.
  task automatic issue_request(deq_pkg::req_t kind, value_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    req_type   <= kind;
    push_value <= value;
    do @(posedge clk); while (req_stall);
    sb.note_request(kind, value);
    if (kind > deq_pkg::REQ_DUMP) ignored_sent++;
    else requests_sent++;
  endtask

  // Holds the request side off until every expected result has arrived.
  task automatic wait_for_results();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic issue_push();
    issue_request($urandom_range(1) ? deq_pkg::REQ_PUSH_BACK : deq_pkg::REQ_PUSH_FRONT,
                  pick_value());
  endtask

  task automatic issue_pop();
    issue_request($urandom_range(1) ? deq_pkg::REQ_POP_BACK : deq_pkg::REQ_POP_FRONT,
                  pick_value());
  endtask

  // One random request of any kind, unused codes now and then.
  task automatic issue_mixed();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) issue_request(deq_pkg::REQ_PUSH_FRONT, pick_value());
    else if (roll < 60) issue_request(deq_pkg::REQ_PUSH_BACK, pick_value());
    else if (roll < 75) issue_request(deq_pkg::REQ_POP_FRONT, pick_value());
    else if (roll < 90) issue_request(deq_pkg::REQ_POP_BACK, pick_value());
    else if (roll < 96) issue_request(deq_pkg::REQ_DUMP, pick_value());
    else issue_request(deq_pkg::req_t'($urandom_range(5, 7)), pick_value());
  endtask

  // Random bursts: fill to full, drain to empty, or a mix of requests.
  // Bursts check the phase's share of items, but fill and drain bursts end with one to three extra pushes or pops.
  task automatic run_phase(int opener);
    int start_count;
    int kind;
    start_count = requests_sent;
    kind = opener;
    while (requests_sent - start_count < PHASE_ITEMS) begin
      case (kind)
        0: begin
          while (sb.mirror_count < DEPTH &&
                 requests_sent - start_count < PHASE_ITEMS) begin
            if ($urandom_range(15) == 0) issue_request(deq_pkg::REQ_DUMP, pick_value());
            else issue_push();
          end
          repeat ($urandom_range(1, 3)) issue_push();
        end
        1: begin
          while (sb.mirror_count > 0 &&
                 requests_sent - start_count < PHASE_ITEMS) begin
            if ($urandom_range(15) == 0) issue_request(deq_pkg::REQ_DUMP, pick_value());
            else issue_pop();
          end
          repeat ($urandom_range(1, 3)) issue_pop();
        end
        default: begin
          repeat ($urandom_range(8, 24)) begin
            if (requests_sent - start_count < PHASE_ITEMS) issue_mixed();
          end
        end
      endcase
      kind = $urandom_range(9);
      if (kind > 2) kind = 2;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 29;
    recv_idle_pct = 59;

    // Directed part: empty cases, unused codes, extreme values, front wrap.
    issue_request(deq_pkg::REQ_DUMP, '0);
    issue_request(deq_pkg::REQ_POP_FRONT, '0);
    issue_request(deq_pkg::REQ_POP_BACK, -1);
    issue_request(deq_pkg::req_t'(5), 32'sh7fff_ffff);
    issue_request(deq_pkg::req_t'(6), 32'sh8000_0000);
    issue_request(deq_pkg::req_t'(7), -1);
    issue_request(deq_pkg::REQ_PUSH_BACK, 32'sh7fff_ffff);
    issue_request(deq_pkg::REQ_PUSH_FRONT, 32'sh8000_0000);
    issue_request(deq_pkg::REQ_PUSH_BACK, -1);
    issue_request(deq_pkg::REQ_PUSH_FRONT, '0);
    issue_request(deq_pkg::REQ_PUSH_BACK, 1);
    issue_request(deq_pkg::REQ_DUMP, '0);
    issue_request(deq_pkg::REQ_POP_BACK, '0);
    issue_request(deq_pkg::REQ_POP_FRONT, '0);
    issue_request(deq_pkg::REQ_DUMP, '0);
    issue_request(deq_pkg::REQ_POP_FRONT, '0);
    issue_request(deq_pkg::REQ_POP_BACK, '0);
    issue_request(deq_pkg::REQ_POP_FRONT, '0);
    issue_request(deq_pkg::REQ_POP_BACK, '0);
    issue_request(deq_pkg::REQ_PUSH_FRONT, 32'sh5555_5555);
    issue_request(deq_pkg::REQ_PUSH_BACK, 32'shAAAA_AAAA);
    issue_request(deq_pkg::REQ_DUMP, '0);
    issue_request(deq_pkg::REQ_POP_FRONT, '0);
    issue_request(deq_pkg::REQ_POP_FRONT, '0);
    issue_request(deq_pkg::REQ_DUMP, '0);

    // Let the block run dry before the random part.
    wait_for_results();

    run_phase(0);
    wait_for_results();

    send_idle_pct = 59;
    recv_idle_pct = 29;
    run_phase(1);
    wait_for_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase($urandom_range(2));

    // Drain and allow time for any stray results.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests plus %0d unused codes, %0d results checked.",
             requests_sent, ignored_sent, sb.checked_count);
    $display("Full pushes seen: %0d, empty pops or dumps seen: %0d.",
             sb.full_hits, sb.empty_hits);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
